// ===== rtl/core/grid_cell_number_unit_defines.svh =====
// Assertion macros for the grid cell number unit.
`ifndef GRID_CELL_NUMBER_UNIT_DEFINES_SVH
`define GRID_CELL_NUMBER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define GCN_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("gcn assertion failed");
`define GCN_ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("gcn forbidden condition");
`else
`define GCN_ASSERT(label, clk, rst, prop)
`define GCN_ASSERT_NEVER(label, clk, rst, expr)
`endif

`endif

// ===== rtl/core/gcn_pkg.sv =====
package gcn_pkg;

  localparam int COORD_W   = 32;
  localparam int CELLS_W   = 31;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int QBITS     = DIFF_W;
  localparam int DIV_LAT   = QBITS + 2;
  localparam int REG_IDX_W = 3;
  localparam int PROD_W    = 2 * CELLS_W;
  localparam int SUM_W     = PROD_W + 1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic [CELLS_W-1:0]        cells_t;

  localparam coord_t INVALID_INDEX = coord_t'(-666);
  localparam coord_t IDX_MAX       = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t IDX_MIN       = {1'b1, {(COORD_W-1){1'b0}}};

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_WIDTH_X  = 3'd2,
    REG_WIDTH_Y  = 3'd3,
    REG_CELLS_X  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    cells_t cell_number;
    logic   on_grid;
    coord_t column_index;
    coord_t row_index;
  } result_t;

endpackage

// ===== rtl/core/gcn_ifs.sv =====
interface gcn_point_if;
  logic            valid;
  logic            ready;
  gcn_pkg::coord_t point_x;
  gcn_pkg::coord_t point_y;
  modport source(output valid, point_x, point_y, input ready);
  modport sink(input valid, point_x, point_y, output ready);
endinterface

interface gcn_result_if;
  logic            valid;
  logic            ready;
  gcn_pkg::cells_t cell_number;
  logic            on_grid;
  gcn_pkg::coord_t column_index;
  gcn_pkg::coord_t row_index;
  modport source(output valid, cell_number, on_grid, column_index, row_index, input ready);
  modport sink(input valid, cell_number, on_grid, column_index, row_index, output ready);
endinterface

interface gcn_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [gcn_pkg::REG_IDX_W-1:0]    reg_index;
  logic [gcn_pkg::COORD_W-1:0]      wdata;
  modport source(output valid, reg_index, wdata, input ready);
  modport sink(input valid, reg_index, wdata, output ready);
endinterface

// ===== rtl/core/grid_cell_number_unit.sv =====
// Path: point word -> difference register -> dividers -> multiply stage -> output register.
// Throughput: one point per cycle while the skid stage is empty; the two
// pipelined 33-stage restoring dividers (one quotient bit per stage) run in parallel.
// Reset (rst, synchronous): origin, widths and cells_x clear to 0, so the
// grid is undefined; all valid bits and the output skid stage clear.
`include "grid_cell_number_unit_defines.svh"

module grid_cell_number_unit (
  input  logic clk,
  input  logic rst,
  gcn_point_if.sink    points,
  gcn_result_if.source results,
  gcn_cfg_if.sink      cfg
);

  gcn_pkg::coord_t origin_x;
  gcn_pkg::coord_t origin_y;
  gcn_pkg::coord_t width_x;
  gcn_pkg::coord_t width_y;
  gcn_pkg::cells_t cells_x;
  logic            defined;

  logic            en;
  logic            v_in;
  gcn_pkg::diff_t  dx;
  gcn_pkg::diff_t  dy;
  logic [gcn_pkg::DIV_LAT-1:0] vd;
  gcn_pkg::coord_t qx;
  gcn_pkg::coord_t qy;

  logic                       vm;
  gcn_pkg::coord_t            col_m;
  gcn_pkg::coord_t            row_m;
  logic [gcn_pkg::PROD_W-1:0] prod_m;
  logic                       range_m;

  logic [gcn_pkg::SUM_W-1:0]  n;
  logic                       ok;
  gcn_pkg::result_t           fin;

  logic             out_valid;
  gcn_pkg::result_t out_data;
  logic             skid_valid;
  gcn_pkg::result_t skid_data;
  logic             take;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
      width_x  <= '0;
      width_y  <= '0;
      cells_x  <= '0;
    end else if (cfg.valid) begin
      case (cfg.reg_index)
        gcn_pkg::REG_ORIGIN_X: origin_x <= cfg.wdata;
        gcn_pkg::REG_ORIGIN_Y: origin_y <= cfg.wdata;
        gcn_pkg::REG_WIDTH_X:  width_x  <= cfg.wdata;
        gcn_pkg::REG_WIDTH_Y:  width_y  <= cfg.wdata;
        gcn_pkg::REG_CELLS_X:  cells_x  <= cfg.wdata[gcn_pkg::CELLS_W-1:0];
        default: ;
      endcase
    end
  end

  assign defined = (cells_x != '0) && (width_x != '0) && (width_y != '0);

  // whole pipe advances unless the skid stage holds a word
  assign en           = !skid_valid;
  assign points.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_in <= 1'b0;
      vd   <= '0;
      vm   <= 1'b0;
    end else if (en) begin
      v_in <= points.valid;
      vd   <= {vd[gcn_pkg::DIV_LAT-2:0], v_in};
      vm   <= vd[gcn_pkg::DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx <= gcn_pkg::DIFF_W'(points.point_x) - gcn_pkg::DIFF_W'(origin_x);
      dy <= gcn_pkg::DIFF_W'(points.point_y) - gcn_pkg::DIFF_W'(origin_y);
    end
  end

  gcn_floor_div u_div_x (
    .clk      (clk),
    .en       (en),
    .dividend (dx),
    .divisor  (width_x),
    .quotient (qx)
  );

  gcn_floor_div u_div_y (
    .clk      (clk),
    .en       (en),
    .dividend (dy),
    .divisor  (width_y),
    .quotient (qy)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      col_m   <= qx;
      row_m   <= qy;
      prod_m  <= gcn_pkg::PROD_W'(qy[gcn_pkg::CELLS_W-1:0])
               * gcn_pkg::PROD_W'(cells_x);
      range_m <= defined && !qx[gcn_pkg::COORD_W-1] && !qy[gcn_pkg::COORD_W-1]
              && (qx[gcn_pkg::CELLS_W-1:0] < cells_x);
    end
  end

  always_comb begin
    n  = {1'b0, prod_m} + gcn_pkg::SUM_W'(col_m[gcn_pkg::CELLS_W-1:0])
       + gcn_pkg::SUM_W'(1);
    ok = range_m && (n[gcn_pkg::SUM_W-1:gcn_pkg::CELLS_W] == '0);
    fin.cell_number  = ok ? n[gcn_pkg::CELLS_W-1:0] : '0;
    fin.on_grid      = ok;
    fin.column_index = defined ? col_m : gcn_pkg::INVALID_INDEX;
    fin.row_index    = defined ? row_m : gcn_pkg::INVALID_INDEX;
  end

  // output register plus one-word skid
  assign take = out_valid && results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || take) begin
      out_valid <= vm;
    end else if (vm) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        out_data <= skid_data;
      end
    end else if (!out_valid || take) begin
      out_data <= fin;
    end else if (vm) begin
      skid_data <= fin;
    end
  end

  assign results.valid        = out_valid;
  assign results.cell_number  = out_data.cell_number;
  assign results.on_grid      = out_data.on_grid;
  assign results.column_index = out_data.column_index;
  assign results.row_index    = out_data.row_index;

  `GCN_ASSERT(a_skid_needs_out, clk, rst, skid_valid |-> out_valid)
  `GCN_ASSERT(a_skid_fill_on_stall, clk, rst,
              $rose(skid_valid) |-> $past(out_valid && !results.ready))
  `GCN_ASSERT(a_skid_holds, clk, rst, (skid_valid && !results.ready) |=> skid_valid)
  `GCN_ASSERT(a_on_grid_has_cell, clk, rst,
              (out_valid && out_data.on_grid) |-> (out_data.cell_number != '0))
  `GCN_ASSERT_NEVER(a_on_grid_neg_index, clk, rst,
                    out_valid && out_data.on_grid
                    && (out_data.column_index[gcn_pkg::COORD_W-1]
                        || out_data.row_index[gcn_pkg::COORD_W-1]))

endmodule

// ===== rtl/core/gcn_floor_div.sv =====
module gcn_floor_div (
  input  logic            clk,
  input  logic            en,
  input  gcn_pkg::diff_t  dividend,
  input  gcn_pkg::coord_t divisor,
  output gcn_pkg::coord_t quotient
);

  logic [gcn_pkg::COORD_W-1:0] dmag;
  logic [gcn_pkg::COORD_W-1:0] rem [0:gcn_pkg::QBITS];
  logic [gcn_pkg::QBITS-1:0]   dq  [0:gcn_pkg::QBITS];
  logic                        neg [0:gcn_pkg::QBITS];

  logic [gcn_pkg::QBITS:0]     mag;
  logic                        sat;
  gcn_pkg::coord_t             fixed;

  assign dmag = divisor[gcn_pkg::COORD_W-1] ? gcn_pkg::COORD_W'(-divisor)
                                             : gcn_pkg::COORD_W'(divisor);

  // magnitude and quotient sign
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= '0;
      dq[0]  <= dividend[gcn_pkg::DIFF_W-1] ? gcn_pkg::QBITS'(-dividend)
                                             : gcn_pkg::QBITS'(dividend);
      neg[0] <= dividend[gcn_pkg::DIFF_W-1] ^ divisor[gcn_pkg::COORD_W-1];
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < gcn_pkg::QBITS; k++) begin : g_step
    logic [gcn_pkg::COORD_W:0] trial;
    logic [gcn_pkg::COORD_W:0] diffv;
    logic                      fits;

    assign trial = {rem[k], dq[k][gcn_pkg::QBITS-1]};
    assign diffv = trial - {1'b0, dmag};
    assign fits  = trial >= {1'b0, dmag};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= fits ? diffv[gcn_pkg::COORD_W-1:0] : trial[gcn_pkg::COORD_W-1:0];
        dq[k+1]  <= {dq[k][gcn_pkg::QBITS-2:0], fits};
        neg[k+1] <= neg[k];
      end
    end
  end

  // floor correction and saturation
  always_comb begin
    mag = {1'b0, dq[gcn_pkg::QBITS]}
        + (gcn_pkg::QBITS+1)'(neg[gcn_pkg::QBITS] && (rem[gcn_pkg::QBITS] != '0));
    if (neg[gcn_pkg::QBITS]) begin
      sat   = mag > ((gcn_pkg::QBITS+1)'($unsigned(gcn_pkg::IDX_MAX)) + 1'b1);
      fixed = sat ? gcn_pkg::IDX_MIN
                  : gcn_pkg::coord_t'(-mag[gcn_pkg::COORD_W-1:0]);
    end else begin
      sat   = mag > (gcn_pkg::QBITS+1)'($unsigned(gcn_pkg::IDX_MAX));
      fixed = sat ? gcn_pkg::IDX_MAX
                  : gcn_pkg::coord_t'(mag[gcn_pkg::COORD_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quotient <= fixed;
    end
  end

endmodule
